@@ design/nwsa_pkg.sv @@
// Shared types, constants and sigmoid table arithmetic for the neuron weighted sum block
`timescale 1ns / 1ps

package nwsa_pkg;

	// Default weight table depth
	localparam int MAX_INPUTS_DEF = 16;

	// Field widths
	localparam int SLOT_W  = 8;
	localparam int VALUE_W = 16;
	localparam int PROD_W  = 32;
	localparam int ACC_W   = 40;
	localparam int BIAS_W  = 32;
	localparam int ACT_W   = 17;

	// Item opcodes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_LOAD   = 1'b1;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'd1;

	// Activation modes
	localparam logic MODE_STEP    = 1'b0;
	localparam logic MODE_SIGMOID = 1'b1;

	// Activation output levels
	localparam logic [ACT_W-1:0] ACT_ZERO = 17'd0;
	localparam logic [ACT_W-1:0] ACT_HALF = 17'd32768;
	localparam logic [ACT_W-1:0] ACT_ONE  = 17'd65536;

	// Sigmoid table: Q4.8 inputs over [-8, 8)
	localparam int SIG_HALF  = 2048;
	localparam int SIG_DEPTH = 2 * SIG_HALF;
	localparam int SIG_AW    = $clog2(SIG_DEPTH);

	// Result queue
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// exp(-1/256) in Q63 from a truncated series
	localparam logic [63:0] SIG_ONE_Q63     = 64'h8000_0000_0000_0000;
	localparam logic [63:0] SIG_QUARTER_Q63 = 64'h4000_0000_0000_0000;
	localparam logic [63:0] SIG_T1  = SIG_ONE_Q63 / 64'd256;
	localparam logic [63:0] SIG_T2  = SIG_T1 / 64'd512;
	localparam logic [63:0] SIG_T3  = SIG_T2 / 64'd768;
	localparam logic [63:0] SIG_T4  = SIG_T3 / 64'd1024;
	localparam logic [63:0] SIG_T5  = SIG_T4 / 64'd1280;
	localparam logic [63:0] SIG_T6  = SIG_T5 / 64'd1536;
	localparam logic [63:0] SIG_T7  = SIG_T6 / 64'd1792;
	localparam logic [63:0] SIG_T8  = SIG_T7 / 64'd2048;
	localparam logic [63:0] SIG_T9  = SIG_T8 / 64'd2304;
	localparam logic [63:0] SIG_T10 = SIG_T9 / 64'd2560;
	localparam logic [63:0] SIG_T11 = SIG_T10 / 64'd2816;
	localparam logic [63:0] SIG_DECAY_Q63 = SIG_ONE_Q63 - SIG_T1 + SIG_T2 - SIG_T3 + SIG_T4
		- SIG_T5 + SIG_T6 - SIG_T7 + SIG_T8 - SIG_T9 + SIG_T10 - SIG_T11;

	// Per-sample control through the MAC stages
	typedef struct packed {
		logic valid;
		logic in_range;
		logic last;
		logic dropped;
	} sample_ctl_t;

	// Finished weighted sum handed to the activation stages
	typedef struct packed {
		logic                    valid;
		logic                    dropped;
		logic signed [ACC_W-1:0] sum;
	} sum_t;

	// One result item
	typedef struct packed {
		logic        [ACT_W-1:0] activation;
		logic signed [ACC_W-1:0] preactivation;
		logic                    overflow_flag;
	} result_t;

	// (a*b) / 2^63, rounded half up
	function automatic logic [63:0] mul_q63(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = 128'(a) * 128'(b);
		p = p + (128'd1 << 62);
		return p[126:63];
	endfunction

	// round(65536 * num / den) by restoring shift-subtract, num < den
	function automatic logic [ACT_W-1:0] ratio_round(input logic [63:0] num,
		input logic [63:0] den);
		logic [63:0] r;
		logic [17:0] q;
		r = num;
		q = '0;
		for (int i = 0; i < 17; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q[0] = 1'b1;
			end
		end
		return ACT_W'((q + 18'd1) >> 1);
	endfunction

endpackage

@@ design/nwsa_in_if.sv @@
// Input item channel: opcode, weight slot, value and last mark
`timescale 1ns / 1ps

interface nwsa_in_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   opcode;
	logic        [nwsa_pkg::SLOT_W-1:0]     weight_slot;
	logic signed [nwsa_pkg::VALUE_W-1:0]    value;
	logic                                   last_sample;

	modport source(output valid, output opcode, output weight_slot, output value,
		output last_sample, input ready);
	modport sink(input valid, input opcode, input weight_slot, input value,
		input last_sample, output ready);
endinterface

@@ design/nwsa_out_if.sv @@
// Result item channel: activation, pre-activation and drop flag
`timescale 1ns / 1ps

interface nwsa_out_if;
	logic                                valid;
	logic                                ready;
	logic        [nwsa_pkg::ACT_W-1:0]   activation;
	logic signed [nwsa_pkg::ACC_W-1:0]   preactivation;
	logic                                overflow_flag;

	modport source(output valid, output activation, output preactivation,
		output overflow_flag, input ready);
	modport sink(input valid, input activation, input preactivation,
		input overflow_flag, output ready);
endinterface

@@ design/nwsa_weight_mac.sv @@
// Weight memory, sample position tracking and multiply-accumulate pipeline
`timescale 1ns / 1ps

module nwsa_weight_mac #(
	parameter int MAX_INPUTS = nwsa_pkg::MAX_INPUTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_take,
	input  logic                                 load_take,
	input  logic        [nwsa_pkg::SLOT_W-1:0]   slot,
	input  logic signed [nwsa_pkg::VALUE_W-1:0]  value,
	input  logic                                 last,
	output nwsa_pkg::sum_t                       sum
);

	localparam int AW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
	localparam int PW = $clog2(MAX_INPUTS + 1);

	logic        [PW-1:0]                    pos_q;
	logic                                    drop_q;
	logic                                    in_range;
	logic                                    slot_ok;
	logic signed [nwsa_pkg::VALUE_W-1:0]     weight_mem_q [MAX_INPUTS];
	logic signed [nwsa_pkg::VALUE_W-1:0]     weight_s1;
	logic signed [nwsa_pkg::VALUE_W-1:0]     value_s1;
	nwsa_pkg::sample_ctl_t                   ctl_s1;
	logic signed [nwsa_pkg::PROD_W-1:0]      prod_s2;
	nwsa_pkg::sample_ctl_t                   ctl_s2;
	logic signed [nwsa_pkg::ACC_W-1:0]       acc_q;
	logic signed [nwsa_pkg::ACC_W-1:0]       acc_next;
	nwsa_pkg::sum_t                          sum_s3;

	assign in_range = pos_q < PW'(MAX_INPUTS);
	assign slot_ok  = {1'b0, slot} < 9'(MAX_INPUTS);

	// Sample position and drop mark, cleared by the last sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			drop_q <= 1'b0;
		end else if (sample_take) begin
			if (last) begin
				pos_q  <= '0;
				drop_q <= 1'b0;
			end else if (in_range) begin
				pos_q <= pos_q + PW'(1);
			end else begin
				drop_q <= 1'b1;
			end
		end
	end

	// Weight memory: one write port for loads, one registered read for samples
	always_ff @(posedge clk) begin
		if (load_take && slot_ok) begin
			weight_mem_q[slot[AW-1:0]] <= value;
		end
		weight_s1 <= weight_mem_q[pos_q[AW-1:0]];
	end

	// Stage 1 control and sample value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid    <= sample_take;
			ctl_s1.in_range <= in_range;
			ctl_s1.last     <= last;
			ctl_s1.dropped  <= drop_q | ~in_range;
		end
	end

	always_ff @(posedge clk) begin
		value_s1 <= value;
		prod_s2  <= value_s1 * weight_s1;
	end

	// Stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	// Accumulate; dropped samples add nothing
	assign acc_next = acc_q + (ctl_s2.in_range
		? {{(nwsa_pkg::ACC_W - nwsa_pkg::PROD_W){prod_s2[nwsa_pkg::PROD_W-1]}}, prod_s2}
		: nwsa_pkg::ACC_W'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			sum_s3 <= '0;
		end else begin
			if (ctl_s2.valid) begin
				if (ctl_s2.last) begin
					acc_q <= '0;
				end else begin
					acc_q <= acc_next;
				end
			end
			sum_s3.valid   <= ctl_s2.valid & ctl_s2.last;
			sum_s3.dropped <= ctl_s2.dropped;
			sum_s3.sum     <= acc_next;
		end
	end

	assign sum = sum_s3;

endmodule

@@ design/nwsa_activation.sv @@
// Bias subtraction, sigmoid clamp and table read, step function
`timescale 1ns / 1ps

module nwsa_activation (
	input  logic                                clk,
	input  logic                                arst_n,
	input  nwsa_pkg::sum_t                      sum,
	input  logic signed [nwsa_pkg::BIAS_W-1:0]  bias,
	input  logic                                mode,
	output logic                                res_valid,
	output nwsa_pkg::result_t                   res
);

	logic        [nwsa_pkg::ACT_W-1:0]       sig_rom_q [nwsa_pkg::SIG_DEPTH];
	logic                                    valid_s4;
	logic                                    drop_s4;
	logic signed [nwsa_pkg::ACC_W-1:0]       pre_s4;
	logic                                    valid_s5;
	logic                                    drop_s5;
	logic                                    step_s5;
	logic signed [nwsa_pkg::ACC_W-1:0]       pre_s5;
	logic        [nwsa_pkg::ACT_W-1:0]       sig_s5;
	logic        [nwsa_pkg::SIG_AW-1:0]      sig_addr;
	logic                                    in_band;

	// Sigmoid table, filled once at start-up; entry a holds sigmoid((a - 2048) / 256)
	initial begin : sig_rom_fill
		logic [63:0] t;
		logic [63:0] d;
		t = nwsa_pkg::SIG_ONE_Q63;
		for (int k = 0; k <= nwsa_pkg::SIG_HALF; k++) begin
			d = nwsa_pkg::SIG_QUARTER_Q63 + (t >> 1);
			if (k < nwsa_pkg::SIG_HALF) begin
				sig_rom_q[nwsa_pkg::SIG_AW'(nwsa_pkg::SIG_HALF + k)] =
					nwsa_pkg::ratio_round(nwsa_pkg::SIG_QUARTER_Q63, d);
			end
			if (k > 0) begin
				sig_rom_q[nwsa_pkg::SIG_AW'(nwsa_pkg::SIG_HALF - k)] =
					nwsa_pkg::ratio_round(t >> 1, d);
			end
			t = nwsa_pkg::mul_q63(t, nwsa_pkg::SIG_DECAY_Q63);
		end
	end

	// Control through stages 4 and 5
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s4 <= sum.valid;
			valid_s5 <= valid_s4;
		end
	end

	// Pre-activation = sum - bias
	always_ff @(posedge clk) begin
		drop_s4 <= sum.dropped;
		pre_s4  <= sum.sum - {{(nwsa_pkg::ACC_W - nwsa_pkg::BIAS_W){bias[nwsa_pkg::BIAS_W-1]}},
			bias};
	end

	// Clamp to [-8, 8) and take the Q4.8 part as table address
	assign in_band = (&pre_s4[nwsa_pkg::ACC_W-1:19]) | ~(|pre_s4[nwsa_pkg::ACC_W-1:19]);

	always_comb begin
		priority if (in_band) begin
			sig_addr = {~pre_s4[19], pre_s4[18:8]};
		end else if (pre_s4[nwsa_pkg::ACC_W-1]) begin
			sig_addr = '0;
		end else begin
			sig_addr = '1;
		end
	end

	// Sigmoid table read, registered
	always_ff @(posedge clk) begin
		sig_s5  <= sig_rom_q[sig_addr];
		pre_s5  <= pre_s4;
		drop_s5 <= drop_s4;
		step_s5 <= ~pre_s4[nwsa_pkg::ACC_W-1];
	end

	assign res_valid         = valid_s5;
	assign res.activation    = (mode == nwsa_pkg::MODE_SIGMOID) ? sig_s5
		: (step_s5 ? nwsa_pkg::ACT_ONE : nwsa_pkg::ACT_ZERO);
	assign res.preactivation = pre_s5;
	assign res.overflow_flag = drop_s5;

endmodule

@@ design/nwsa_result_fifo.sv @@
// Result queue with credit count covering results still in the pipeline
`timescale 1ns / 1ps

module nwsa_result_fifo (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 reserve,
	input  logic                                 wr_en,
	input  nwsa_pkg::result_t                    wr_data,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output nwsa_pkg::result_t                    out_data,
	output logic                                 space,
	output logic [nwsa_pkg::FIFO_AW:0]           fill
);

	localparam int CW = nwsa_pkg::FIFO_AW + 1;

	nwsa_pkg::result_t                  fifo_mem_q [nwsa_pkg::FIFO_DEPTH];
	logic [nwsa_pkg::FIFO_AW-1:0]       wr_ptr_q;
	logic [nwsa_pkg::FIFO_AW-1:0]       rd_ptr_q;
	logic [CW-1:0]                      fill_q;
	logic [CW-1:0]                      credit_q;
	logic                               pop;

	assign out_valid = fill_q != '0;
	assign pop       = out_valid & out_ready;
	assign out_data  = fifo_mem_q[rd_ptr_q];
	assign space     = credit_q < CW'(nwsa_pkg::FIFO_DEPTH);
	assign fill      = fill_q;

	// Storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			fifo_mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers, fill level and credits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			credit_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + nwsa_pkg::FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + nwsa_pkg::FIFO_AW'(1);
			end
			fill_q   <= fill_q + CW'(wr_en) - CW'(pop);
			credit_q <= credit_q + CW'(reserve) - CW'(pop);
		end
	end

endmodule

@@ design/neuron_weighted_sum_activation.sv @@
// Top level of the single neuron: weighted sum, bias and step or sigmoid activation
`timescale 1ns / 1ps
// Throughput: one item per cycle while input ready is high, loads and samples alike.
// A result can transfer once its last sample's transfer has passed the weight read,
// multiply, accumulate, bias subtract, sigmoid table read and queue registers.
// Up to 8 results may be in flight or queued; input ready drops while all are taken.
// Reset: accumulator, position, drop mark, bias (0) and mode (step) clear at once;
// weight memory contents are undefined until loaded.

module neuron_weighted_sum_activation #(
	parameter int MAX_INPUTS = nwsa_pkg::MAX_INPUTS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	nwsa_in_if.sink                               item,
	nwsa_out_if.source                            result,
	input  logic                                  cfg_we,
	input  logic [nwsa_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [nwsa_pkg::BIAS_W-1:0]           cfg_data
);

	logic signed [nwsa_pkg::BIAS_W-1:0]   bias_q;
	logic                                 mode_q;
	logic                                 take;
	logic                                 sample_take;
	logic                                 load_take;
	logic                                 space;
	nwsa_pkg::sum_t                       sum;
	logic                                 act_valid;
	nwsa_pkg::result_t                    act_res;
	nwsa_pkg::result_t                    out_data;
	logic [nwsa_pkg::FIFO_AW:0]           fill;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= '0;
			mode_q <= nwsa_pkg::MODE_STEP;
		end else if (cfg_we) begin
			unique case (cfg_index)
				nwsa_pkg::REG_BIAS: bias_q <= cfg_data;
				nwsa_pkg::REG_MODE: mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Input transfer decode
	assign item.ready  = space;
	assign take        = item.valid & item.ready;
	assign sample_take = take & (item.opcode == nwsa_pkg::OP_SAMPLE);
	assign load_take   = take & (item.opcode == nwsa_pkg::OP_LOAD);

	nwsa_weight_mac #(
		.MAX_INPUTS(MAX_INPUTS)
	) u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_take(sample_take),
		.load_take  (load_take),
		.slot       (item.weight_slot),
		.value      (item.value),
		.last       (item.last_sample),
		.sum        (sum)
	);

	nwsa_activation u_act (
		.clk      (clk),
		.arst_n   (arst_n),
		.sum      (sum),
		.bias     (bias_q),
		.mode     (mode_q),
		.res_valid(act_valid),
		.res      (act_res)
	);

	nwsa_result_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.reserve  (sample_take & item.last_sample),
		.wr_en    (act_valid),
		.wr_data  (act_res),
		.out_ready(result.ready),
		.out_valid(result.valid),
		.out_data (out_data),
		.space    (space),
		.fill     (fill)
	);

	assign result.activation    = out_data.activation;
	assign result.preactivation = out_data.preactivation;
	assign result.overflow_flag = out_data.overflow_flag;

`ifndef SYNTHESIS
	// Credits must keep a slot free for every result leaving the pipeline
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		act_valid |-> fill < (nwsa_pkg::FIFO_AW + 1)'(nwsa_pkg::FIFO_DEPTH))
		else $error("result written into a full queue");

	// Step output follows the sign of the pre-activation
	a_step_sign: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && mode_q == nwsa_pkg::MODE_STEP |->
		result.activation == (result.preactivation[nwsa_pkg::ACC_W-1]
			? nwsa_pkg::ACT_ZERO : nwsa_pkg::ACT_ONE))
		else $error("step activation disagrees with pre-activation sign");

	// Sigmoid table addressing: half or above exactly for non-negative inputs
	a_sig_half: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && mode_q == nwsa_pkg::MODE_SIGMOID |->
		(result.activation >= nwsa_pkg::ACT_HALF) == !result.preactivation[nwsa_pkg::ACC_W-1])
		else $error("sigmoid activation on wrong side of one half");
`endif

endmodule
